FILE: hdl/serial_command_frame_parser_macros.svh
// Assertion macros shared by the frame parser RTL.
`ifndef SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define SCFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define SCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/scfp_pkg.sv
// Types and constants of the serial command frame parser.
package scfp_pkg;

  // Frame framing and decode constants.
  localparam logic [7:0] SyncFirst    = 8'hAA;
  localparam logic [7:0] SyncSecond   = 8'h55;
  localparam logic [7:0] KindVelocity = 8'h01;
  localparam int unsigned StoreDepth  = 8;
  localparam int unsigned StoreIdxW   = $clog2(StoreDepth);

  // Parser phases, one-hot coded.
  typedef enum logic [5:0] {
    PH_HEAD1   = 6'b000001,
    PH_HEAD2   = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_TYPE    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CHECK   = 6'b100000
  } parse_phase_e;

  // Status reported with each finished frame.
  typedef enum logic [1:0] {
    STATUS_VELOCITY = 2'd0,
    STATUS_BAD_SUM  = 2'd1,
    STATUS_OTHER    = 2'd2
  } frame_status_e;

  typedef logic [7:0] byte_t;

endpackage

FILE: hdl/scfp_byte_if.sv
// Valid/ready channel that carries one received serial byte.
interface scfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/scfp_result_if.sv
// Valid/ready channel that carries one parsed frame result.
interface scfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  frame_kind;
  logic [31:0] linear_speed_word;
  logic [31:0] turn_rate_word;

  modport source (output valid, output frame_status, output frame_kind,
                  output linear_speed_word, output turn_rate_word, input ready);
  modport sink (input valid, input frame_status, input frame_kind,
                input linear_speed_word, input turn_rate_word, output ready);
endinterface

FILE: hdl/serial_command_frame_parser.sv
// Serial command frame parser: header hunt, XOR checksum and command decode.
//
//  Channel  | Dir | Payload                                               | Transaction
//  ---------+-----+-------------------------------------------------------+----------------
//  byte_i   | in  | rx_byte[7:0]                                          | valid && ready
//  res_o    | out | frame_status[1:0], frame_kind[7:0], linear_speed_word | valid && ready
//           |     | [31:0], turn_rate_word[31:0]                          |
//
// One byte is taken per cycle while no checksum byte waits on a stalled result register.
// The byte goes through an input register, then the phase and checksum logic, whose frame
// result lands in the result register.
// rst_ni clears the phase and the valid flags; the parser then hunts for the header.
// A stalled result register holds only a checksum byte in the input register, which then
// drops byte_i.ready; all other bytes keep flowing while a result waits.
module serial_command_frame_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  scfp_byte_if.sink       byte_i,
  scfp_result_if.source   res_o
);
  import scfp_pkg::*;

  `include "serial_command_frame_parser_macros.svh"

  // Input register.
  logic  byte_vld_q;
  byte_t byte_q;

  // Parser state.
  parse_phase_e phase_q, phase_d;
  byte_t        len_q;
  byte_t        kind_q;
  byte_t        count_q;
  byte_t        xor_q;
  byte_t        store_q [StoreDepth];

  // Result register.
  logic          res_vld_q;
  frame_status_e res_status_q;
  byte_t         res_kind_q;
  logic [31:0]   res_lin_q;
  logic [31:0]   res_turn_q;

  // Frame verdict on the checksum byte.
  frame_status_e status_d;
  logic          is_check;
  assign is_check = (phase_q == PH_CHECK);

  // Pipeline control: only a checksum byte needs room in the result register.
  logic advance;
  logic fire;
  assign advance      = !res_vld_q || res_o.ready;
  assign fire         = byte_vld_q && (advance || !is_check);
  assign byte_i.ready = !byte_vld_q || fire;

  // Input register load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      byte_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      byte_q <= byte_i.rx_byte;
    end
  end

  // Payload count after this byte, saturating, and the frame end test.
  byte_t count_inc;
  byte_t needed;
  logic  payload_done;
  logic  store_room;
  assign count_inc    = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
  assign needed       = (len_q > 8'd1) ? len_q - 8'd1 : 8'd1;
  assign payload_done = count_inc >= needed;
  assign store_room   = count_q < 8'(StoreDepth);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HEAD1:   if (byte_q == SyncFirst) phase_d = PH_HEAD2;
      PH_HEAD2:   phase_d = (byte_q == SyncSecond) ? PH_LEN : PH_HEAD1;
      PH_LEN:     phase_d = PH_TYPE;
      PH_TYPE:    phase_d = PH_PAYLOAD;
      PH_PAYLOAD: if (payload_done) phase_d = PH_CHECK;
      PH_CHECK:   phase_d = PH_HEAD1;
      default:    phase_d = PH_HEAD1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
    end else if (fire) begin
      phase_q <= phase_d;
    end
  end

  // Frame fields, running checksum and payload count.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (phase_q == PH_LEN) begin
        len_q   <= byte_q;
        count_q <= '0;
        xor_q   <= byte_q;
      end
      if (phase_q == PH_TYPE) begin
        kind_q <= byte_q;
        xor_q  <= xor_q ^ byte_q;
      end
      if (phase_q == PH_PAYLOAD) begin
        xor_q   <= xor_q ^ byte_q;
        count_q <= count_inc;
      end
    end
  end

  // Command store: cleared at the length byte, filled by the first payload bytes.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < StoreDepth; i++) begin
      if (fire && phase_q == PH_LEN) begin
        store_q[i] <= '0;
      end else if (fire && phase_q == PH_PAYLOAD && store_room &&
                   count_q[StoreIdxW-1:0] == StoreIdxW'(i)) begin
        store_q[i] <= byte_q;
      end
    end
  end

  // Status decode of the checksum byte.
  always_comb begin
    if (xor_q != byte_q) begin
      status_d = STATUS_BAD_SUM;
    end else if (kind_q == KindVelocity) begin
      status_d = STATUS_VELOCITY;
    end else begin
      status_d = STATUS_OTHER;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= fire && is_check;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_check) begin
      res_status_q <= status_d;
      res_kind_q   <= kind_q;
      if (status_d == STATUS_VELOCITY) begin
        res_lin_q  <= {store_q[3], store_q[2], store_q[1], store_q[0]};
        res_turn_q <= {store_q[7], store_q[6], store_q[5], store_q[4]};
      end else begin
        res_lin_q  <= '0;
        res_turn_q <= '0;
      end
    end
  end

  assign res_o.valid             = res_vld_q;
  assign res_o.frame_status      = res_status_q;
  assign res_o.frame_kind        = res_kind_q;
  assign res_o.linear_speed_word = res_lin_q;
  assign res_o.turn_rate_word    = res_turn_q;

  // Assertions.
  `SCFP_ASSERT_NEXT(a_check_gives_result, fire && is_check,
                    res_vld_q && phase_q == PH_HEAD1, "checksum byte did not produce a result")
  `SCFP_ASSERT_NEXT(a_no_spurious_result, advance && !(byte_vld_q && is_check),
                    !res_vld_q, "result raised without a checksum byte")
  `SCFP_ASSERT_SAME(a_words_zero_unless_velocity,
                    res_vld_q && res_status_q != STATUS_VELOCITY,
                    res_lin_q == '0 && res_turn_q == '0,
                    "command words not cleared on non-velocity result")
  `SCFP_ASSERT_SAME(a_payload_count_bounded, phase_q == PH_PAYLOAD, count_q < 8'd254,
                    "payload count ran past the longest frame")
  `SCFP_ASSERT_NEXT(a_input_held_on_stall, byte_vld_q && !fire,
                    byte_vld_q && $stable(byte_q), "input register lost a byte while stalled")

endmodule
